// ===== hdl/jrac_pkg.sv =====
// Shared types and constants of the job/rank address cache.
`timescale 1ns / 1ps

package jrac_pkg;

  // Operation codes carried in the kind field
  localparam logic [1:0] KIND_UPDATE = 2'd0;
  localparam logic [1:0] KIND_LOOKUP = 2'd1;
  localparam logic [1:0] KIND_CLEAR  = 2'd2;

  // Result status codes
  localparam logic [1:0] STATUS_DONE    = 2'd0;
  localparam logic [1:0] STATUS_NO_SLOT = 2'd1;
  localparam logic [1:0] STATUS_BAD_RANK = 2'd2;

  // Task id returned when nothing is stored
  localparam logic [31:0] ABSENT_ID = 32'hFFFF_FFFF;

  // Entry epoch: epoch zero never matches, so a swept entry reads as invalid
  localparam int unsigned EPOCH_W = 8;
  localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
  localparam logic [EPOCH_W-1:0] EPOCH_LAST  = {EPOCH_W{1'b1}};

  typedef enum logic [2:0] {
    ST_INIT_SWEEP,
    ST_IDLE,
    ST_DECODE,
    ST_ACCESS,
    ST_CLR_SWEEP,
    ST_RESP
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;    // capture the input transaction
    logic decode;  // match tags, claim a slot, form the address
    logic access;  // memory read or write, clear bookkeeping
    logic sweep;   // write one entry of the invalidation sweep
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic wrap;        // clear in progress runs out of epochs
    logic sweep_last;  // sweep is at its last entry
  } dp_sts_t;

endpackage

// ===== hdl/jrac_if.sv =====
// Valid/ready channel interfaces for requests and responses.
`timescale 1ns / 1ps

interface jrac_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic signed [31:0] job_id;
  logic signed [16:0] rank;
  logic signed [31:0] task_id;

  modport source (output valid, kind, job_id, rank, task_id, input ready);
  modport sink   (input valid, kind, job_id, rank, task_id, output ready);
endinterface

interface jrac_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] found_task_id;
  logic [1:0]         status;

  modport source (output valid, found_task_id, status, input ready);
  modport sink   (input valid, found_task_id, status, output ready);
endinterface

// ===== hdl/jrac_ctrl.sv =====
// Sequencing state machine of the job/rank address cache.
`timescale 1ns / 1ps

module jrac_ctrl
  import jrac_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    req_valid,
  output logic    req_ready,
  output logic    rsp_valid,
  input  logic    rsp_ready,
  output dp_cmd_t cmd,
  input  dp_sts_t sts
);

  state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT_SWEEP;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_INIT_SWEEP: begin
        if (sts.sweep_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (req_valid) state_next = ST_DECODE;
      end
      ST_DECODE: begin
        state_next = ST_ACCESS;
      end
      ST_ACCESS: begin
        state_next = sts.wrap ? ST_CLR_SWEEP : ST_RESP;
      end
      ST_CLR_SWEEP: begin
        if (sts.sweep_last) state_next = ST_RESP;
      end
      ST_RESP: begin
        if (rsp_ready) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_INIT_SWEEP;
      end
    endcase
  end

  // Outputs
  always_comb begin
    cmd       = '0;
    req_ready = 1'b0;
    rsp_valid = 1'b0;
    case (state)
      ST_INIT_SWEEP: begin
        cmd.sweep = 1'b1;
      end
      ST_IDLE: begin
        req_ready = 1'b1;
        cmd.load  = req_valid;
      end
      ST_DECODE: begin
        cmd.decode = 1'b1;
      end
      ST_ACCESS: begin
        cmd.access = 1'b1;
      end
      ST_CLR_SWEEP: begin
        cmd.sweep = 1'b1;
      end
      ST_RESP: begin
        rsp_valid = 1'b1;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ===== hdl/jrac_dp.sv =====
// Datapath: tag slots, entry memory with epoch marks, result registers.
`timescale 1ns / 1ps

module jrac_dp
  import jrac_pkg::*;
#(
  parameter int JOB_SLOTS  = 8,
  parameter int RANK_SLOTS = 4096
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic signed [31:0] cfg_wdata,
  input  logic [1:0]         kind,
  input  logic signed [31:0] job_id,
  input  logic signed [16:0] rank,
  input  logic signed [31:0] task_id,
  output logic signed [31:0] found_task_id,
  output logic [1:0]         status,
  input  dp_cmd_t            cmd,
  output dp_sts_t            sts
);

  localparam int SLOT_W  = (JOB_SLOTS > 1) ? $clog2(JOB_SLOTS) : 1;
  localparam int TABLES  = JOB_SLOTS + 1;
  localparam int TABLE_W = $clog2(TABLES);
  localparam int DEPTH   = TABLES * RANK_SLOTS;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int RIDX_W  = $clog2(RANK_SLOTS);
  localparam int WORD_W  = EPOCH_W + 32;

  // Configuration and captured transaction
  logic [31:0] own_job_id;
  logic [1:0]  kind_q;
  logic [31:0] job_q;
  logic [16:0] rank_q;
  logic [31:0] task_q;

  // Tag slots
  logic [31:0]          job_tags [JOB_SLOTS];
  logic [JOB_SLOTS-1:0] slot_used;

  // Decode results
  logic              do_write;
  logic              do_read;
  logic              do_clear;
  logic [ADDR_W-1:0] addr;
  logic [1:0]        status_q;

  // Memory and epoch state
  logic [WORD_W-1:0]  mem [DEPTH];
  logic [WORD_W-1:0]  rd_word;
  logic [EPOCH_W-1:0] epoch;
  logic [ADDR_W-1:0]  sweep_cnt;

  // Combinational decode
  logic               is_local;
  logic [JOB_SLOTS-1:0] match;
  logic               hit;
  logic [SLOT_W-1:0]  hit_idx;
  logic               any_free;
  logic [SLOT_W-1:0]  free_idx;
  logic               rank_ok;
  logic [TABLE_W-1:0] table_sel;
  logic               claim;
  logic               have_table;
  logic [ADDR_W-1:0]  addr_next;
  logic [1:0]         status_next;

  logic               mem_we;
  logic [ADDR_W-1:0]  mem_addr;
  logic [WORD_W-1:0]  mem_wdata;

  // Hold the configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      own_job_id <= '0;
    end else if (cfg_we) begin
      own_job_id <= cfg_wdata;
    end
  end

  // Capture the accepted transaction
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_q <= kind;
      job_q  <= job_id;
      rank_q <= rank;
      task_q <= task_id;
    end
  end

  // Compare the job against every slot in parallel
  always_comb begin
    for (int i = 0; i < JOB_SLOTS; i++) begin
      match[i] = slot_used[i] && (job_tags[i] == job_q);
    end
  end

  // Pick the matching slot and the lowest free slot
  always_comb begin
    hit      = 1'b0;
    hit_idx  = '0;
    any_free = 1'b0;
    free_idx = '0;
    for (int i = 0; i < JOB_SLOTS; i++) begin
      if (!hit && match[i]) begin
        hit     = 1'b1;
        hit_idx = SLOT_W'(i);
      end
      if (!any_free && !slot_used[i]) begin
        any_free = 1'b1;
        free_idx = SLOT_W'(i);
      end
    end
  end

  // Select table, status and entry address
  always_comb begin
    is_local   = (job_q == '0) || (job_q == own_job_id);
    rank_ok    = !rank_q[16] && ({1'b0, rank_q[15:0]} < 17'(RANK_SLOTS));
    claim      = (kind_q == KIND_UPDATE) && !is_local && !hit && any_free;
    have_table = is_local || hit || claim;
    if (is_local) begin
      table_sel = '0;
    end else if (hit) begin
      table_sel = TABLE_W'(hit_idx) + TABLE_W'(1);
    end else begin
      table_sel = TABLE_W'(free_idx) + TABLE_W'(1);
    end
    addr_next = ADDR_W'(table_sel) * ADDR_W'(RANK_SLOTS) + ADDR_W'(rank_q[RIDX_W-1:0]);
    status_next = STATUS_DONE;
    if (kind_q == KIND_UPDATE) begin
      if (!have_table) begin
        status_next = STATUS_NO_SLOT;
      end else if (!rank_ok) begin
        status_next = STATUS_BAD_RANK;
      end
    end
  end

  // Register the decode and claim a new slot
  always_ff @(posedge clk) begin
    if (cmd.decode) begin
      do_write <= (kind_q == KIND_UPDATE) && have_table && rank_ok;
      do_read  <= (kind_q == KIND_LOOKUP) && have_table && rank_ok;
      do_clear <= (kind_q == KIND_CLEAR);
      addr     <= addr_next;
      status_q <= status_next;
    end
    if (cmd.decode && claim) begin
      job_tags[free_idx] <= job_q;
    end
  end

  // Track used slots; clear frees all of them
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_used <= '0;
    end else if (cmd.access && do_clear) begin
      slot_used <= '0;
    end else if (cmd.decode && claim) begin
      slot_used[free_idx] <= 1'b1;
    end
  end

  // Advance the epoch on clear; wrap it back to the first epoch after the last
  always_ff @(posedge clk) begin
    if (rst) begin
      epoch <= EPOCH_FIRST;
    end else if (cmd.access && do_clear) begin
      epoch <= (epoch == EPOCH_LAST) ? EPOCH_FIRST : epoch + EPOCH_W'(1);
    end
  end

  assign sts.wrap       = do_clear && (epoch == EPOCH_LAST);
  assign sts.sweep_last = (sweep_cnt == ADDR_W'(DEPTH - 1));

  // Step through the memory during a sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_cnt <= '0;
    end else if (cmd.sweep) begin
      sweep_cnt <= sts.sweep_last ? '0 : sweep_cnt + ADDR_W'(1);
    end
  end

  // Memory port selection
  assign mem_we    = cmd.sweep || (cmd.access && do_write);
  assign mem_addr  = cmd.sweep ? sweep_cnt : addr;
  assign mem_wdata = cmd.sweep ? '0 : {epoch, task_q};

  // Entry memory: one write or one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (cmd.access && do_read) begin
      rd_word <= mem[mem_addr];
    end
  end

  // Drive the result: an entry counts only with the current epoch
  always_comb begin
    found_task_id = ABSENT_ID;
    if (do_read && (rd_word[WORD_W-1:32] == epoch)) begin
      found_task_id = rd_word[31:0];
    end
  end

  assign status = status_q;

endmodule

// ===== hdl/job_rank_address_cache_core.sv =====
// Job/rank address cache: maps (job, rank) to a task id, one transaction at a time.
// Flow: an accepted request passes through the decode and access states to the response;
//   a new request is taken only after the response has been taken.
// A clear follows the same path, except each clear that exhausts the 8-bit entry epoch
//   adds a sweep over all (JOB_SLOTS+1)*RANK_SLOTS memory entries (36864 by default).
// Reset: synchronous; the block then sweeps all (JOB_SLOTS+1)*RANK_SLOTS memory entries
//   before it takes requests; configuration writes are taken throughout.
`timescale 1ns / 1ps

module job_rank_address_cache_core
  import jrac_pkg::*;
#(
  parameter int JOB_SLOTS  = 8,
  parameter int RANK_SLOTS = 4096
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic signed [31:0] cfg_wdata,
  jrac_req_if.sink           req,
  jrac_rsp_if.source         rsp
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  // Sequencer
  jrac_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Tag match, memory and result
  jrac_dp #(
    .JOB_SLOTS  (JOB_SLOTS),
    .RANK_SLOTS (RANK_SLOTS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .kind          (req.kind),
    .job_id        (req.job_id),
    .rank          (req.rank),
    .task_id       (req.task_id),
    .found_task_id (rsp.found_task_id),
    .status        (rsp.status),
    .cmd           (cmd),
    .sts           (sts)
  );

endmodule

// ===== tb/sv/job_rank_address_cache_core_tb.sv =====
// Testbench for the job/rank address cache: self-checking random and directed traffic.
`timescale 1ns / 1ps

module job_rank_address_cache_core_tb;
  import jrac_pkg::*;

  localparam int JOB_SLOTS      = 8;
  localparam int RANK_SLOTS     = 4096;
  localparam int TABLES         = JOB_SLOTS + 1;
  localparam int POOL_SIZE      = 12;
  localparam int WATCHDOG_LIMIT = 120000;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  typedef struct {
    logic [1:0]         kind;
    logic signed [31:0] job_id;
    logic signed [16:0] rank;
    logic signed [31:0] task_id;
  } cache_req_t;

  typedef struct {
    logic signed [31:0] found_task_id;
    logic [1:0]         status;
  } cache_reply_t;

  logic               clk;
  logic               rst;
  logic               cfg_we;
  logic signed [31:0] cfg_wdata;

  jrac_req_if req_if ();
  jrac_rsp_if rsp_if ();

  job_rank_address_cache_core #(
    .JOB_SLOTS  (JOB_SLOTS),
    .RANK_SLOTS (RANK_SLOTS)
  ) uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req_if),
    .rsp       (rsp_if)
  );

  // Shadow copy of the cache state
  logic signed [31:0] own_job_copy;
  logic signed [31:0] tag_copy[JOB_SLOTS];
  bit                 slot_busy[JOB_SLOTS];
  logic signed [31:0] entry_copy[TABLES*RANK_SLOTS];
  bit                 entry_live[TABLES*RANK_SLOTS];

  cache_req_t   pending_requests[$];
  cache_reply_t predicted_replies[$];
  logic [48:0]  recent_pairs[$];

  logic signed [31:0] job_pool[POOL_SIZE];
  logic signed [16:0] hot_ranks[8];
  bit                 pool_ready;

  int unsigned fail_count;
  int unsigned replies_checked;
  int unsigned n_updates, n_lookups, n_hits, n_clears, n_unused;
  int unsigned n_no_slot, n_bad_rank, n_settings;

  int unsigned gap_left, burst_left;
  logic [15:0] ready_pattern;
  int unsigned pattern_age;
  int unsigned quiet_cycles;
  cache_req_t   taken_req, next_req;
  cache_reply_t want;

  always #6 clk = ~clk;

  // Table for a job: 0 own table, 1+slot sister table, -1 unknown or no free slot
  function automatic int job_table(logic signed [31:0] job, bit claim);
    if (job == 0 || job == own_job_copy) return 0;
    for (int i = 0; i < JOB_SLOTS; i++)
      if (slot_busy[i] && tag_copy[i] == job) return 1 + i;
    if (!claim) return -1;
    for (int i = 0; i < JOB_SLOTS; i++) begin
      if (!slot_busy[i]) begin
        slot_busy[i] = 1'b1;
        tag_copy[i]  = job;
        return 1 + i;
      end
    end
    return -1;
  endfunction

  // Apply one transaction to the shadow state and return the reply it must produce
  function automatic cache_reply_t apply_to_cache_copy(cache_req_t r);
    cache_reply_t res;
    int           tbl;
    int           idx;
    bit           rank_ok;
    res.found_task_id = ABSENT_ID;
    res.status        = STATUS_DONE;
    rank_ok = !r.rank[16] && (int'(r.rank[15:0]) < RANK_SLOTS);
    case (r.kind)
      KIND_UPDATE: begin
        n_updates++;
        tbl = job_table(r.job_id, 1'b1);
        if (tbl < 0) begin
          res.status = STATUS_NO_SLOT;
          n_no_slot++;
        end else if (!rank_ok) begin
          res.status = STATUS_BAD_RANK;
          n_bad_rank++;
        end else begin
          idx = tbl * RANK_SLOTS + int'(r.rank[15:0]);
          entry_copy[idx] = r.task_id;
          entry_live[idx] = 1'b1;
        end
      end
      KIND_LOOKUP: begin
        n_lookups++;
        tbl = job_table(r.job_id, 1'b0);
        if (tbl >= 0 && rank_ok) begin
          idx = tbl * RANK_SLOTS + int'(r.rank[15:0]);
          if (entry_live[idx]) begin
            res.found_task_id = entry_copy[idx];
            n_hits++;
          end
        end
      end
      KIND_CLEAR: begin
        n_clears++;
        foreach (slot_busy[i]) slot_busy[i] = 1'b0;
        foreach (entry_live[i]) entry_live[i] = 1'b0;
      end
      default: n_unused++;
    endcase
    return res;
  endfunction

  function automatic logic signed [16:0] pick_rank();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 5))
          0: return -17'sd1;
          1: return 17'sh10000;
          2: return 17'(RANK_SLOTS);
          3: return 17'h0FFFF;
          4: return 17'($urandom_range(RANK_SLOTS, 65535));
          default: return {1'b1, 16'($urandom)};
        endcase
      end
      1: return 17'($urandom_range(0, RANK_SLOTS - 1));
      default: return hot_ranks[$urandom_range(0, 7)];
    endcase
  endfunction

  function automatic logic signed [31:0] pick_job();
    if ($urandom_range(0, 9) == 0) return $urandom;
    return job_pool[$urandom_range(0, POOL_SIZE - 1)];
  endfunction

  // Mostly updates and lookups that revisit recent updates; clears rare unless clear heavy, the unused kind rare
  function automatic cache_req_t make_request(bit clear_heavy);
    cache_req_t  r;
    int unsigned roll;
    roll      = $urandom_range(0, 99);
    r.task_id = $urandom;
    r.job_id  = pick_job();
    r.rank    = pick_rank();
    if (clear_heavy ? roll < 30 : roll < 44) begin
      r.kind = KIND_UPDATE;
      recent_pairs.push_back({r.job_id, r.rank});
      if (recent_pairs.size() > 16) void'(recent_pairs.pop_front());
    end else if (clear_heavy ? roll < 50 : roll < 95) begin
      r.kind = KIND_LOOKUP;
      if (recent_pairs.size() != 0 && $urandom_range(0, 9) < 6)
        {r.job_id, r.rank} = recent_pairs[$urandom_range(0, recent_pairs.size() - 1)];
    end else if (clear_heavy || roll < 98) begin
      r.kind = KIND_CLEAR;
    end else begin
      r.kind = KIND_UNUSED;
    end
    return r;
  endfunction

  // Refresh the job pool around the current own job; part of it carries over between phases
  function automatic void refresh_pool();
    job_pool[0] = 32'sd0;
    job_pool[1] = own_job_copy;
    job_pool[2] = 32'sh7FFF_FFFF;
    job_pool[3] = 32'sh8000_0000;
    job_pool[4] = -32'sd1;
    job_pool[5] = 32'sd1;
    for (int i = 6; i < POOL_SIZE; i++)
      if (!pool_ready || i < 9) job_pool[i] = $urandom;
    hot_ranks = '{17'sd0, 17'sd1, 17'sd2, 17'(RANK_SLOTS - 1), 17'(RANK_SLOTS - 2),
                  17'(RANK_SLOTS / 2), 17'($urandom_range(0, RANK_SLOTS - 1)),
                  17'($urandom_range(0, RANK_SLOTS - 1))};
    pool_ready = 1'b1;
  endfunction

  task automatic push_req(logic [1:0] kind, logic signed [31:0] job,
                          logic signed [16:0] rank, logic signed [31:0] task_id);
    cache_req_t r;
    r.kind    = kind;
    r.job_id  = job;
    r.rank    = rank;
    r.task_id = task_id;
    pending_requests.push_back(r);
  endtask

  // Hold the sender until every queued transaction has been answered; look between edges
  // so the driver and monitor updates of the last edge have settled
  task automatic wait_drained();
    while (pending_requests.size() != 0 || req_if.valid || predicted_replies.size() != 0)
      @(negedge clk);
  endtask

  task automatic set_own_job(logic signed [31:0] value);
    wait_drained();
    @(posedge clk);
    cfg_we       <= 1'b1;
    cfg_wdata    <= value;
    own_job_copy = value;
    n_settings++;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_random(int unsigned count, bit clear_heavy);
    refresh_pool();
    repeat (count) pending_requests.push_back(make_request(clear_heavy));
  endtask

  // Request driver: bursts of random length separated by random gaps
  always @(posedge clk) begin
    if (rst) begin
      req_if.valid <= 1'b0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        taken_req.kind    = req_if.kind;
        taken_req.job_id  = req_if.job_id;
        taken_req.rank    = req_if.rank;
        taken_req.task_id = req_if.task_id;
        predicted_replies.push_back(apply_to_cache_copy(taken_req));
      end
      if (!req_if.valid || req_if.ready) begin
        if (gap_left != 0) begin
          gap_left--;
          req_if.valid <= 1'b0;
        end else if (pending_requests.size() != 0) begin
          next_req = pending_requests.pop_front();
          req_if.valid   <= 1'b1;
          req_if.kind    <= next_req.kind;
          req_if.job_id  <= next_req.job_id;
          req_if.rank    <= next_req.rank;
          req_if.task_id <= next_req.task_id;
          if (burst_left != 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 19);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Response monitor: check each transaction against the oldest prediction, stall on a pattern
  always @(posedge clk) begin
    if (rst) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (predicted_replies.size() == 0) begin
          $error("unexpected response: found_task_id %h status %0d",
                 rsp_if.found_task_id, rsp_if.status);
          fail_count++;
        end else begin
          want = predicted_replies.pop_front();
          replies_checked++;
          if (rsp_if.found_task_id !== want.found_task_id) begin
            $error("found_task_id: expected %h, actual %h",
                   want.found_task_id, rsp_if.found_task_id);
            fail_count++;
          end
          if (rsp_if.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, rsp_if.status);
            fail_count++;
          end
        end
      end
      // Pick a new stall pattern now and then: none, random, or mostly ready
      pattern_age++;
      if (pattern_age >= 97) begin
        pattern_age = 0;
        case ($urandom_range(0, 2))
          0: ready_pattern = 16'hFFFF;
          1: ready_pattern = 16'($urandom);
          default: ready_pattern = 16'($urandom) | 16'($urandom);
        endcase
      end
      rsp_if.ready  <= ready_pattern[0];
      ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
    end
  end

  // Watchdog: abort when no transaction moves for too long
  always @(posedge clk) begin
    if (rst || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    clk            = 1'b0;
    rst            = 1'b1;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    req_if.valid   = 1'b0;
    req_if.kind    = KIND_LOOKUP;
    req_if.job_id  = '0;
    req_if.rank    = '0;
    req_if.task_id = '0;
    rsp_if.ready   = 1'b0;
    own_job_copy   = '0;
    ready_pattern  = 16'hFFFF;
    foreach (slot_busy[i]) slot_busy[i] = 1'b0;
    foreach (entry_live[i]) entry_live[i] = 1'b0;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: rank extremes, bad ranks, slot exhaustion, unused kind, clear
    set_own_job(32'sd0);
    push_req(KIND_LOOKUP, 32'sd0, 17'sd0, 32'sd0);
    push_req(KIND_UPDATE, 32'sd0, 17'sd0, 32'sh7FFF_FFFF);
    push_req(KIND_LOOKUP, 32'sd0, 17'sd0, 32'sd0);
    push_req(KIND_UPDATE, 32'sd0, 17'(RANK_SLOTS - 1), 32'sh8000_0000);
    push_req(KIND_LOOKUP, 32'sd0, 17'(RANK_SLOTS - 1), -32'sd1);
    push_req(KIND_UPDATE, 32'sd0, 17'(RANK_SLOTS), 32'sd5);
    push_req(KIND_UPDATE, 32'sd0, -17'sd1, 32'sd6);
    push_req(KIND_UPDATE, 32'sd0, 17'h0FFFF, 32'sd7);
    push_req(KIND_UPDATE, 32'sd0, 17'sh10000, 32'sd8);
    push_req(KIND_LOOKUP, 32'sd0, -17'sd1, 32'sd0);
    push_req(KIND_LOOKUP, 32'sh1234_5678, 17'sd1, 32'sd0);
    push_req(KIND_UPDATE, 32'sh7FFF_FFFF, 17'sd5000, 32'sd9);
    push_req(KIND_UPDATE, 32'sh8000_0000, 17'sd1, 32'sd0);
    push_req(KIND_UPDATE, -32'sd1, 17'sd1, -32'sd1);
    for (int j = 1; j <= 5; j++) push_req(KIND_UPDATE, j, 17'sd1, $urandom);
    push_req(KIND_UPDATE, 32'sd6, 17'sd1, 32'sd10);
    push_req(KIND_LOOKUP, 32'sh7FFF_FFFF, 17'sd5000, 32'sd0);
    push_req(KIND_LOOKUP, 32'sh7FFF_FFFF, 17'sd1, 32'sd0);
    push_req(KIND_LOOKUP, -32'sd1, 17'sd1, 32'sd0);
    push_req(KIND_UNUSED, 32'sd0, 17'sd0, 32'sd11);
    push_req(KIND_CLEAR, 32'sd0, 17'sd0, 32'sd0);
    push_req(KIND_LOOKUP, -32'sd1, 17'sd1, 32'sd0);
    push_req(KIND_LOOKUP, 32'sd0, 17'sd0, 32'sd0);

    // Random phases across own job settings; one phase is clear heavy to wrap the epoch
    set_own_job(32'sh7FFF_FFFF);
    load_random(300, 1'b0);
    set_own_job(32'sh8000_0000);
    load_random(300, 1'b0);
    wait_drained();
    set_own_job(slot_busy[0] ? tag_copy[0] : job_pool[6]);
    load_random(300, 1'b0);
    set_own_job($urandom);
    load_random(500, 1'b1);
    set_own_job(32'sd0);
    load_random(250, 1'b0);

    wait_drained();
    repeat (20) @(posedge clk);

    $display("Covered %0d updates (%0d no job slot, %0d bad rank), %0d lookups (%0d hits),",
             n_updates, n_no_slot, n_bad_rank, n_lookups, n_hits);
    $display("%0d clears, %0d unused kinds, %0d own job settings, %0d responses checked",
             n_clears, n_unused, n_settings, replies_checked);
    if (fail_count == 0 && predicted_replies.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
